>>> sv/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder package
// Shared types, character constants and lookup functions for the decoder.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] BYTE_SHORT   = 8'hFE;
    localparam logic [7:0] BYTE_SPLIT   = 8'h7F;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESC    = 4'b0010,
        MODE_HEX1   = 4'b0100,
        MODE_HEX2   = 4'b1000
    } esc_mode_t;

    typedef enum logic [1:0] {
        ESC_MAPPED,
        ESC_PASS,
        ESC_HEX
    } esc_kind_t;

    typedef struct packed {
        esc_kind_t  kind;
        logic [7:0] data;
    } esc_map_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       fin;
    } esc_result_t;

    typedef struct packed {
        logic [1:0]  num;
        esc_result_t r0;
        esc_result_t r1;
    } esc_push_t;

    function automatic esc_map_t esc_map(input logic [7:0] ch);
        esc_map_t m;
        m.kind = ESC_MAPPED;
        m.data = 8'h00;
        case (ch)
            8'h6E:   m.data = 8'h0A;
            8'h62:   m.data = 8'h08;
            8'h72:   m.data = 8'h0D;
            8'h61:   m.data = 8'h07;
            8'h65:   m.data = 8'h1B;
            8'h74:   m.data = 8'h09;
            8'h76:   m.data = 8'h0B;
            8'h5C:   m.data = 8'h5C;
            8'h66:   m.data = 8'h0C;
            8'h22:   m.data = 8'h22;
            8'h30:   m.data = 8'h00;
            8'h3F:   m.data = 8'h3F;
            CH_X:    m.kind = ESC_HEX;
            default: m.kind = ESC_PASS;
        endcase
        return m;
    endfunction

    function automatic hex_digit_t hex_digit(input logic [7:0] ch);
        hex_digit_t d;
        logic [7:0] diff;
        d.ok = 1'b1;
        diff = 8'h00;
        if (ch inside {[8'h30:8'h39]})
        begin
            diff = ch - 8'h30;
        end
        else if (ch inside {[8'h61:8'h66]})
        begin
            diff = ch - 8'h57;
        end
        else if (ch inside {[8'h41:8'h46]})
        begin
            diff = ch - 8'h37;
        end
        else
        begin
            d.ok = 1'b0;
        end
        d.val = diff[3:0];
        return d;
    endfunction

endpackage

>>> sv/esc_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder core
// Holds the decode mode and pending hex character and turns one registered
// input byte into zero, one or two result transfers.
// ----------------------------------------------------------------------------
module esc_decode
    import esc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       is_final,
    output esc_push_t  push
);

    esc_mode_t  mode_reg, mode_next;
    logic [7:0] first_reg, first_next;

    esc_map_t    emap;
    hex_digit_t  d0, d1;
    logic [7:0]  hex_val;
    esc_push_t   raw;

    always_comb
    begin
        emap = esc_map(in_byte);
        d0   = hex_digit(first_reg);
        d1   = hex_digit(in_byte);
        if (!d0.ok)
        begin
            hex_val = 8'h00;
        end
        else if (!d1.ok)
        begin
            hex_val = {4'h0, d0.val};
        end
        else
        begin
            hex_val = {d0.val, d1.val};
        end
    end

    always_comb
    begin
        raw        = '0;
        mode_next  = MODE_NORMAL;
        first_next = first_reg;
        case (mode_reg)
            MODE_NORMAL:
            begin
                if (in_byte == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_byte != CH_QUOTE)
                begin
                    raw.num = 2'd1;
                    raw.r0  = '{data: in_byte, valid: 1'b1, fin: 1'b0};
                end
            end
            MODE_ESC:
            begin
                case (emap.kind)
                    ESC_PASS:
                    begin
                        raw.num = 2'd1;
                        raw.r0  = '{data: in_byte, valid: 1'b1, fin: 1'b0};
                    end
                    ESC_HEX:
                    begin
                        if (is_final)
                        begin
                            raw.num = 2'd1;
                            raw.r0  = '{data: BYTE_SHORT, valid: 1'b1, fin: 1'b0};
                        end
                        else
                        begin
                            mode_next = MODE_HEX1;
                        end
                    end
                    default:
                    begin
                        raw.num = 2'd1;
                        raw.r0  = '{data: emap.data, valid: 1'b1, fin: 1'b0};
                    end
                endcase
            end
            MODE_HEX1:
            begin
                if (is_final)
                begin
                    raw.num = 2'd1;
                    raw.r0  = '{data: BYTE_SHORT, valid: 1'b1, fin: 1'b0};
                    if (in_byte != CH_BACKSLASH && in_byte != CH_QUOTE)
                    begin
                        raw.num = 2'd2;
                        raw.r1  = '{data: in_byte, valid: 1'b1, fin: 1'b0};
                    end
                end
                else
                begin
                    first_next = in_byte;
                    mode_next  = MODE_HEX2;
                end
            end
            default:
            begin
                first_next = 8'h00;
                raw.num    = 2'd1;
                if (hex_val[7])
                begin
                    raw.num = 2'd2;
                    raw.r0  = '{data: BYTE_SPLIT, valid: 1'b1, fin: 1'b0};
                    raw.r1  = '{data: hex_val - 8'd127, valid: 1'b1, fin: 1'b0};
                end
                else
                begin
                    raw.r0 = '{data: hex_val, valid: 1'b1, fin: 1'b0};
                end
            end
        endcase

        push = raw;
        if (is_final)
        begin
            mode_next  = MODE_NORMAL;
            first_next = 8'h00;
            case (raw.num)
                2'd0:
                begin
                    push.num = 2'd1;
                    push.r0  = '{data: 8'h00, valid: 1'b0, fin: 1'b1};
                end
                2'd1:    push.r0.fin = 1'b1;
                default: push.r1.fin = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            first_reg <= 8'h00;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> sv/esc_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder result queue
// Small queue that takes up to two results per cycle and hands out one per cycle unless res_stall holds it.
// ----------------------------------------------------------------------------
module esc_out_queue
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  esc_push_t         push,
    output logic              room,
    output logic [QCNT_W-1:0] level,
    output logic              res_valid,
    input  logic              res_stall,
    output esc_result_t       head
);

    esc_result_t       entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        num;
    logic              pop;

    assign num       = fire ? push.num : 2'd0;
    assign pop       = res_valid && !res_stall;
    assign res_valid = (cnt_reg != '0);
    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign level     = cnt_reg;
    assign head      = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(num);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(num) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (num != 2'd0)
        begin
            entry_reg[wr_reg] <= push.r0;
        end
        if (num == 2'd2)
        begin
            entry_reg[wr_reg + QPTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> sv/escape_sequence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Decodes backslash escapes in a byte stream, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle when not stalled and returns
// decoded bytes in order. An accepted byte is decoded while it sits in the
// input register, and its results enter the queue as it leaves that register.
// Results leave through a four-entry queue at one transfer per cycle unless
// res_stall is high; a byte that yields two results (a hex value above 127,
// or a string that ends one character after x other than backslash or quote)
// leaves as two transfers, and input is stalled while the input register
// holds a byte and the queue has fewer than two free entries.
module escape_sequence_decoder
    import esc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_final,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_final
);

    logic              in_full_reg, in_full_next;
    logic [7:0]        byte_reg;
    logic              final_reg;
    logic              room;
    logic              fire;
    logic              accept;
    logic [QCNT_W-1:0] level;
    esc_push_t         push;
    esc_result_t       head;

    assign fire     = in_full_reg && room;
    assign in_stall = in_full_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (fire)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= in_byte;
            final_reg <= is_final;
        end
    end

    esc_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .in_byte  (byte_reg),
        .is_final (final_reg),
        .push     (push)
    );

    esc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .push      (push),
        .room      (room),
        .level     (level),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .head      (head)
    );

    assign out_byte  = head.data;
    assign out_valid = head.valid;
    assign out_final = head.fin;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && final_reg |-> push.num != 2'd0)
        else $error("final byte produced no result");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && push.num != 2'd0 |=> res_valid)
        else $error("decoded result not presented");

    a_bare_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
        fire && push.num != 2'd0 && !push.r0.valid |-> push.r0.fin && push.r0.data == 8'h00)
        else $error("bare end marker malformed");

endmodule
